// ----- rtl/core/tga_pkg.sv -----
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared phase type, status codes and sizes of the TGA stream decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

	localparam int PalEntries  = 256;
	localparam int PalAddrW    = $clog2(PalEntries);
	localparam int HeaderLen   = 18;
	localparam int OutDataW    = 40;
	localparam int OutUserW    = 3;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_ID,
		PH_LOAD,
		PH_SKIP,
		PH_PIXEL,
		PH_DONE,
		PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		ST_PIXEL     = 3'd0,
		ST_BAD_INDEX = 3'd1,
		ST_BAD_TYPE  = 3'd2,
		ST_BAD_DEPTH = 3'd3,
		ST_MAP_BIG   = 3'd4
	} status_t;

	typedef struct packed {
		logic                wr_en;
		logic [PalAddrW-1:0] wr_addr;
		logic [31:0]         wr_data;
		logic                rd_en;
		logic [PalAddrW-1:0] rd_addr;
	} pal_req_t;

endpackage

// ----- rtl/core/tga_pal_ram.sv -----
// ----------------------------------------------------------------------------
// TGA palette RAM
// Single-port-write, single-port-read color map store with registered read.
// ----------------------------------------------------------------------------
module tga_pal_ram (
	input  logic            clk,
	input  tga_pkg::pal_req_t req,
	output logic [31:0]     rd_data
);
	import tga_pkg::*;

	logic [31:0] mem [PalEntries];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ----- rtl/core/tga_image_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// TGA image stream decoder
// Byte-serial TGA parser and pixel decoder producing RGBA runs.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Contents
//  s_*      | in  | tdata[7:0] data_byte, tuser[0] first_byte
//  m_*      | out | tdata red,green,blue,alpha,repeat_count; tlast image_done;
//           |     | tuser[2:0] status
//
// One byte is taken per cycle while s_tready is high. A byte is decoded in the
// cycle it is accepted; its result (if any) is registered together with the
// palette RAM read data, then pushed into a four-entry output queue.
// Reset clears all control state; the palette RAM is not cleared, since only
// entries written by the current file are ever read.
// s_tready drops only when the queue plus the result in flight fill all four
// slots, so a stalled master side throttles the input after four results.
module tga_image_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
	                               // [31:24] alpha, [39:32] repeat_count
	output logic        m_tlast,   // image_done
	output logic [2:0]  m_tuser    // [2:0] status
);
	import tga_pkg::*;

	// Parser state.
	phase_t      phase_q;
	logic [17:0] bc_q;
	logic [7:0]  idl_q, kind_q, hasp_q, pebits_q, pbits_q, pk_q;
	logic [15:0] plen_q, w_q, h_q;
	logic [31:0] pl_q, g_q, area_q;
	logic        run_q;

	// Next-state values.
	phase_t      ph;
	logic [17:0] bc;
	logic [7:0]  idl, kind, hasp, pebits, pbits, pk;
	logic [15:0] plen, w, h;
	logic [31:0] pl, g;
	logic        run;

	logic        acc, first, go_map, go_pix, indexed, rle;
	logic [7:0]  b, rep;
	logic [4:0]  bpp;
	logic [5:0]  skip_eb;
	logic [15:0] idx, lidx;
	logic [31:0] rgba;
	logic        emit, done, use_pal;
	status_t     st;
	pal_req_t    pal_req;
	logic [31:0] pal_rd;

	// Result stage.
	logic        v_s1, pal_s1, done_s1;
	logic [31:0] rgba_s1;
	logic [7:0]  rep_s1;
	status_t     st_s1;

	// Output queue.
	logic [OutDataW+OutUserW:0] q_mem [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign acc   = s_tvalid && s_tready;
	assign b     = s_tdata;
	assign first = s_tuser[0];
	assign pop   = m_tvalid && m_tready;
	assign s_tready = ({1'b0, cnt_q} + {3'b000, v_s1}) < 4'd4;

	always_comb begin
		ph = phase_q; bc = bc_q; idl = idl_q; kind = kind_q; hasp = hasp_q;
		plen = plen_q; pebits = pebits_q; w = w_q; h = h_q; pbits = pbits_q;
		pl = pl_q; pk = pk_q; run = run_q; g = g_q;
		go_map = 1'b0; go_pix = 1'b0;
		emit = 1'b0; done = 1'b0; use_pal = 1'b0; st = ST_PIXEL;
		rgba = '0; rep = '0; idx = '0; lidx = '0; bpp = '0; skip_eb = '0;
		indexed = 1'b0; rle = 1'b0;
		pal_req = '0;
		if (first) begin
			// A new file restarts header parsing from scratch.
			ph = PH_HEADER; bc = '0; idl = '0; kind = '0; hasp = '0; plen = '0;
			pebits = '0; w = '0; h = '0; pbits = '0; pl = '0; pk = '0;
			run = 1'b0; g = '0;
		end
		indexed = (kind == 8'd1) || (kind == 8'd9);
		rle     = kind >= 8'd9;
		case (ph)
			PH_HEADER: begin
				case (bc[4:0])
					5'd0:  idl = b;
					5'd1:  hasp = b;
					5'd2:  kind = b;
					5'd5:  plen = {8'h00, b};
					5'd6:  plen = {b, plen[7:0]};
					5'd7:  pebits = b;
					5'd12: w = {8'h00, b};
					5'd13: w = {b, w[7:0]};
					5'd14: h = {8'h00, b};
					5'd15: h = {b, h[7:0]};
					5'd16: pbits = b;
					default: ;
				endcase
				bc = bc + 18'd1;
				if (bc >= 18'(HeaderLen)) begin
					bc = '0;
					if (indexed) begin
						if (pebits != 8'd24 && pebits != 8'd32) st = ST_BAD_DEPTH;
						else if (plen > 16'(PalEntries)) st = ST_MAP_BIG;
						else if (pbits != 8'd8 && pbits != 8'd16) st = ST_BAD_DEPTH;
					end else if (kind == 8'd2 || kind == 8'd10) begin
						if (pbits != 8'd24 && pbits != 8'd32) st = ST_BAD_DEPTH;
					end else if (kind == 8'd3 || kind == 8'd11) begin
						if (pbits != 8'd8) st = ST_BAD_DEPTH;
					end else begin
						st = ST_BAD_TYPE;
					end
					if (st != ST_PIXEL) begin
						emit = 1'b1;
						ph = PH_HALT;
					end else if (idl != 8'd0) begin
						ph = PH_ID;
						bc = {10'd0, idl};
					end else begin
						go_map = 1'b1;
					end
				end
			end
			PH_ID: begin
				bc = bc - 18'd1;
				if (bc == '0) go_map = 1'b1;
			end
			PH_LOAD: begin
				g = g | ({24'd0, b} << {pk[1:0], 3'b000});
				pk = pk + 8'd1;
				if (pk >= {3'b000, pebits[7:3]}) begin
					lidx = plen - bc[15:0];
					pal_req.wr_en   = lidx[15:PalAddrW] == '0;
					pal_req.wr_addr = lidx[PalAddrW-1:0];
					pal_req.wr_data = {(pebits[7:3] == 5'd4) ? g[31:24] : 8'hFF,
						g[7:0], g[15:8], g[23:16]};
					pk = '0; g = '0;
					bc = bc - 18'd1;
					if (bc == '0) go_pix = 1'b1;
				end
			end
			PH_SKIP: begin
				skip_eb = 6'(({1'b0, pebits} + 9'd7) >> 3);
				pk = pk + 8'd1;
				if (pk >= {2'b00, skip_eb}) begin
					pk = '0;
					bc = bc - 18'd1;
					if (bc == '0) go_pix = 1'b1;
				end
			end
			PH_PIXEL: begin
				if (rle && pk == 8'd0) begin
					run = b[7];
					pk = {1'b0, b[6:0]} + 8'd1;
					bc = '0; g = '0;
				end else begin
					g = g | ({24'd0, b} << {bc[1:0], 3'b000});
					bc = bc + 18'd1;
					bpp = (indexed || kind == 8'd2 || kind == 8'd10) ? pbits[7:3] : 5'd1;
					if (bc >= {13'd0, bpp}) begin
						bc = '0;
						emit = 1'b1;
						if (indexed) begin
							idx = (pbits == 8'd16) ? g[15:0] : {8'h00, g[7:0]};
						end
						if (indexed && idx >= plen) begin
							st = ST_BAD_INDEX;
							ph = PH_HALT;
						end else begin
							if (indexed) begin
								use_pal = 1'b1;
								pal_req.rd_en = 1'b1;
								pal_req.rd_addr = idx[PalAddrW-1:0];
							end else if (kind == 8'd3 || kind == 8'd11) begin
								rgba = {8'hFF, g[7:0], g[7:0], g[7:0]};
							end else begin
								rgba = {(pbits == 8'd32) ? g[31:24] : 8'hFF,
									g[7:0], g[15:8], g[23:16]};
							end
							if (rle && run) begin
								rep = ({24'd0, pk} > pl) ? pl[7:0] : pk;
								pk = '0;
							end else begin
								rep = 8'd1;
								if (rle) pk = pk - 8'd1;
							end
							pl = pl - {24'd0, rep};
							done = pl == '0;
							if (done) ph = PH_DONE;
						end
						g = '0;
					end
				end
			end
			default: ;
		endcase
		if (go_map) begin
			pk = '0; g = '0; bc = {2'b00, plen};
			if (indexed) begin
				if (plen == '0) go_pix = 1'b1;
				else ph = PH_LOAD;
			end else if (hasp != 8'd0 && plen != '0 && pebits != 8'd0) begin
				ph = PH_SKIP;
			end else begin
				go_pix = 1'b1;
			end
		end
		if (go_pix) begin
			pl = area_q; pk = '0; run = 1'b0; bc = '0; g = '0;
			ph = (area_q == '0) ? PH_DONE : PH_PIXEL;
		end
		if (!acc) begin
			pal_req.wr_en = 1'b0;
			pal_req.rd_en = 1'b0;
		end
	end

	tga_pal_ram u_pal (
		.clk     (clk),
		.req     (pal_req),
		.rd_data (pal_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			bc_q <= '0; idl_q <= '0; kind_q <= '0; hasp_q <= '0; plen_q <= '0;
			pebits_q <= '0; w_q <= '0; h_q <= '0; pbits_q <= '0; pl_q <= '0;
			pk_q <= '0; run_q <= 1'b0; g_q <= '0; area_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			// Pixel count is registered from the size fields; two header bytes follow.
			area_q <= w_q * h_q;
			v_s1   <= acc && emit;
			if (acc) begin
				phase_q <= ph; bc_q <= bc; idl_q <= idl; kind_q <= kind;
				hasp_q <= hasp; plen_q <= plen; pebits_q <= pebits; w_q <= w;
				h_q <= h; pbits_q <= pbits; pl_q <= pl; pk_q <= pk; run_q <= run;
				g_q <= g;
			end
		end
	end

	always_ff @(posedge clk) begin
		pal_s1  <= use_pal;
		rgba_s1 <= rgba;
		rep_s1  <= rep;
		done_s1 <= done;
		st_s1   <= st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (v_s1) wp_q <= wp_q + 2'd1;
			if (pop)  rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b00, v_s1} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			q_mem[wp_q] <= {st_s1, done_s1, rep_s1, pal_s1 ? pal_rd : rgba_s1};
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = q_mem[rp_q][OutDataW-1:0];
	assign m_tlast  = q_mem[rp_q][OutDataW];
	assign m_tuser  = q_mem[rp_q][OutDataW+OutUserW:OutDataW+1];

	// Queue plus in-flight result never exceed the queue depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + {3'b000, v_s1}) <= 4'd4)
		else $error("output queue overflow");

	// Error results carry an all-zero payload.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_PIXEL) |-> (m_tdata == '0 && !m_tlast))
		else $error("error result with payload");

	// Pixel runs always cover at least one pixel.
	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_PIXEL) |-> (m_tdata[39:32] != 8'd0))
		else $error("empty pixel run");

endmodule
